FILE: rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, constants and helpers of the servo pulse sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W   = $clog2(CHANNELS + 1);
	localparam int RAM_AW   = CH_W + 1;
	localparam int RAM_D    = 2 ** RAM_AW;
	localparam int WIDTH_W  = 16;
	localparam int LINES_W  = 8;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [1:0] REG_FRAME_TICKS = 2'd0;
	localparam logic [1:0] REG_MIN_WIDTH   = 2'd1;
	localparam logic [1:0] REG_MAX_WIDTH   = 2'd2;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [1:0] {
		ST_NONE     = 2'd0,
		ST_ACCEPTED = 2'd1,
		ST_REJECTED = 2'd2
	} wr_status_t;

	typedef struct packed {
		logic [LINES_W-1:0] lines;
		logic               frame_start;
		wr_status_t         status;
		logic               running;
	} result_t;

	// First set bit of mask at or above from, or CHANNELS when there is none.
	function automatic logic [SLOT_W-1:0] pick_from(input logic [CHANNELS-1:0] mask,
		input logic [SLOT_W-1:0] from);
		logic [SLOT_W-1:0] res;
		res = SLOT_W'(CHANNELS);
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (mask[i] && (SLOT_W'(i) >= from)) begin
				res = SLOT_W'(i);
			end
		end
		return res;
	endfunction

	function automatic logic [WIDTH_W-1:0] sat_add(input logic [WIDTH_W-1:0] a,
		input logic [WIDTH_W-1:0] b);
		logic [WIDTH_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WIDTH_W] ? {WIDTH_W{1'b1}} : s[WIDTH_W-1:0];
	endfunction

endpackage

FILE: rtl/sps_ram.sv
// ----------------------------------------------------------------------------
// sps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/servo_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// servo_pulse_sequencer
// Multiplexed servo pulse sequencer: channel widths are snapshotted at each
// frame start and played back to back, one pulse line high at a time.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    op, channel, pin_valid, width
//  out       output     out_valid / out_stall  pulse_lines, frame_start,
//                                              write_status, running
//  config    input      APB (psel/penable)     frame_ticks, min_width, max_width
//
// A new transaction is taken each cycle while in_stall is low; each gives one
// registered result. Widths live in a 16-entry RAM with two copies per
// channel: writes go to the copy the running frame does not use, and a frame
// start only swaps per-channel bank flags. The width of a newly started pulse
// comes from the registered RAM read port in the next cycle and is folded into
// the pulse end there. Reset needs no clearing pass. An output register plus a
// skid register let input be taken while one result waits.
// ----------------------------------------------------------------------------
module servo_pulse_sequencer import sps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [3:0]         channel,
	input  logic               pin_valid,
	input  logic [WIDTH_W-1:0] width,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [LINES_W-1:0] pulse_lines,
	output logic               frame_start,
	output logic [1:0]         write_status,
	output logic               running,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	// Configuration registers.
	logic [WIDTH_W-1:0] frame_ticks_q, min_width_q, max_width_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ticks_q <= WIDTH_W'(20000);
			min_width_q   <= WIDTH_W'(500);
			max_width_q   <= WIDTH_W'(2500);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_FRAME_TICKS: frame_ticks_q <= pwdata[WIDTH_W-1:0];
				REG_MIN_WIDTH:   min_width_q   <= pwdata[WIDTH_W-1:0];
				REG_MAX_WIDTH:   max_width_q   <= pwdata[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_FRAME_TICKS: prdata = DATA_W'(frame_ticks_q);
			REG_MIN_WIDTH:   prdata = DATA_W'(min_width_q);
			REG_MAX_WIDTH:   prdata = DATA_W'(max_width_q);
			default:         prdata = '0;
		endcase
	end

	// Sequencer state.
	logic [WIDTH_W-1:0]  frame_time_q, pulse_end_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                pend_q, run_q;
	logic [CHANNELS-1:0] mask_q, active_bank_q, latest_bank_q, nz_q;
	logic                fwd_q;
	logic [WIDTH_W-1:0]  fwd_data_q;

	logic [WIDTH_W-1:0]  frame_time_n, pulse_end_n;
	logic [SLOT_W-1:0]   slot_n;
	logic                pend_n, run_n;
	logic [CHANNELS-1:0] mask_n, active_bank_n, latest_bank_n, nz_n;

	logic                accept;
	logic                ram_we, ram_re;
	logic [RAM_AW-1:0]   ram_waddr, ram_raddr;
	logic [WIDTH_W-1:0]  ram_wdata, ram_rdata, rd_width, pulse_end_eff;
	logic [CH_W-1:0]     wr_ch;
	logic [WIDTH_W:0]    tick_time, frame_len;
	logic                wr_ok, begin_fr;
	logic [SLOT_W-1:0]   first_slot, next_slot;
	result_t             res;

	sps_ram #(
		.WIDTH(WIDTH_W),
		.DEPTH(RAM_D)
	) u_width_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// A pulse started in the previous cycle still needs its width added.
	assign rd_width      = fwd_q ? fwd_data_q : ram_rdata;
	assign pulse_end_eff = pend_q ? sat_add(pulse_end_q, rd_width) : pulse_end_q;

	assign wr_ch     = channel[CH_W-1:0];
	assign tick_time = {1'b0, frame_time_q} + (WIDTH_W+1)'(1);
	assign frame_len = (frame_ticks_q == '0) ? (WIDTH_W+1)'(1) : {1'b0, frame_ticks_q};
	assign wr_ok     = ({28'd0, channel} < 32'(CHANNELS)) &&
		((width == '0) || ((width >= min_width_q) && (width <= max_width_q)));

	always_comb begin
		frame_time_n  = frame_time_q;
		pulse_end_n   = pulse_end_eff;
		slot_n        = slot_q;
		pend_n        = 1'b0;
		run_n         = run_q;
		mask_n        = mask_q;
		active_bank_n = active_bank_q;
		latest_bank_n = latest_bank_q;
		nz_n          = nz_q;
		ram_we        = 1'b0;
		ram_waddr     = {~active_bank_q[wr_ch], wr_ch};
		ram_wdata     = (!pin_valid || width == '0) ? '0 : width;
		ram_re        = 1'b0;
		ram_raddr     = '0;
		begin_fr      = 1'b0;
		res.frame_start = 1'b0;
		res.status      = ST_NONE;

		if (accept) begin
			if (op == OP_TICK) begin
				if (run_q) begin
					if (tick_time >= frame_len) begin
						begin_fr = 1'b1;
					end else begin
						frame_time_n = tick_time[WIDTH_W-1:0];
						if ((slot_q < SLOT_W'(CHANNELS)) &&
							(tick_time[WIDTH_W-1:0] >= pulse_end_eff)) begin
							slot_n = next_slot;
							if (next_slot < SLOT_W'(CHANNELS)) begin
								pend_n    = 1'b1;
								ram_re    = 1'b1;
								ram_raddr = {active_bank_q[next_slot[CH_W-1:0]],
									next_slot[CH_W-1:0]};
							end
						end
					end
				end
			end else if (!wr_ok) begin
				res.status = ST_REJECTED;
			end else begin
				res.status           = ST_ACCEPTED;
				// Writes always land in the copy that the running frame does not read.
				ram_we               = 1'b1;
				latest_bank_n[wr_ch] = ~active_bank_q[wr_ch];
				nz_n[wr_ch]          = (ram_wdata != '0);
				if (!run_q && (nz_n != '0)) begin
					begin_fr = 1'b1;
				end
			end

			if (begin_fr) begin
				active_bank_n = latest_bank_n;
				mask_n        = nz_n;
				frame_time_n  = '0;
				pulse_end_n   = '0;
				if (first_slot < SLOT_W'(CHANNELS)) begin
					slot_n          = first_slot;
					run_n           = 1'b1;
					pend_n          = 1'b1;
					ram_re          = 1'b1;
					ram_raddr       = {latest_bank_n[first_slot[CH_W-1:0]],
						first_slot[CH_W-1:0]};
					res.frame_start = 1'b1;
				end else begin
					slot_n = '0;
					run_n  = 1'b0;
				end
			end
		end

		for (int i = 0; i < LINES_W; i++) begin
			res.lines[i] = run_n && (i < CHANNELS) && (slot_n == SLOT_W'(i));
		end
		res.running = run_n;
	end

	assign first_slot = pick_from(nz_n, '0);
	assign next_slot  = pick_from(mask_q, slot_q + SLOT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_time_q  <= '0;
			pulse_end_q   <= '0;
			slot_q        <= '0;
			pend_q        <= 1'b0;
			run_q         <= 1'b0;
			mask_q        <= '0;
			active_bank_q <= '0;
			latest_bank_q <= '0;
			nz_q          <= '0;
			fwd_q         <= 1'b0;
		end else begin
			frame_time_q  <= frame_time_n;
			pulse_end_q   <= pulse_end_n;
			slot_q        <= slot_n;
			pend_q        <= pend_n;
			run_q         <= run_n;
			mask_q        <= mask_n;
			active_bank_q <= active_bank_n;
			latest_bank_q <= latest_bank_n;
			nz_q          <= nz_n;
			// A start by write may read the entry written in the same cycle.
			fwd_q         <= ram_we && ram_re && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= ram_wdata;
	end

	// Output register with a skid stage.
	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q, take;

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign take     = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign pulse_lines  = out_q.lines;
	assign frame_start  = out_q.frame_start;
	assign write_status = out_q.status;
	assign running      = out_q.running;

endmodule
